// ===== design/dpsu_pkg.sv =====
// Shared types, register map and constants of the dual encoder period and speed unit.
package dpsu_pkg;

  // Default sizes of the capture values and of the overflow counters
  localparam int CAPTURE_WIDTH_DEF        = 16;
  localparam int OVERFLOW_COUNT_WIDTH_DEF = 8;

  // Fixed field widths
  localparam int MOD_W     = 16;
  localparam int MAXOVF_W  = 8;
  localparam int SCALE_W   = 32;
  localparam int SPEED_W   = SCALE_W + 1;
  localparam int DIV_CNT_W = $clog2(SCALE_W);

  // Configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_MODULUS = 2'd0,
    REG_MAX_OVF = 2'd1,
    REG_SCALE   = 2'd2
  } reg_idx_t;

  localparam logic [MOD_W-1:0]    MODULUS_RST = 16'hFFFF;
  localparam logic [MAXOVF_W-1:0] MAX_OVF_RST = 8'd10;
  localparam logic [SCALE_W-1:0]  SCALE_RST   = 32'd1000000;

  typedef struct packed {
    logic [MOD_W-1:0]    modulus;
    logic [MAXOVF_W-1:0] max_ovf;
    logic [SCALE_W-1:0]  scale;
  } cfg_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic update;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

endpackage

// ===== design/dpsu_cfg.sv =====
// APB register file for modulus, overflow limit and speed scale.
module dpsu_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dpsu_pkg::ADDR_W-1:0]     paddr,
  input  logic [dpsu_pkg::DATA_W-1:0]     pwdata,
  output logic [dpsu_pkg::DATA_W-1:0]     prdata,
  output logic                            pready,
  output dpsu_pkg::cfg_t                  cfg
);
  import dpsu_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[IDX_W+1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.modulus <= MODULUS_RST;
      cfg.max_ovf <= MAX_OVF_RST;
      cfg.scale   <= SCALE_RST;
    end else if (wr_en) begin
      case (idx)
        REG_MODULUS: cfg.modulus <= pwdata[MOD_W-1:0];
        REG_MAX_OVF: cfg.max_ovf <= pwdata[MAXOVF_W-1:0];
        REG_SCALE:   cfg.scale   <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_MODULUS: prdata = DATA_W'(cfg.modulus);
      REG_MAX_OVF: prdata = DATA_W'(cfg.max_ovf);
      REG_SCALE:   prdata = DATA_W'(cfg.scale);
      default:     prdata = '0;
    endcase
  end

endmodule

// ===== design/dpsu_div.sv =====
// Restoring divider, one quotient bit per step.
module dpsu_div #(
  parameter int DVS_W = 25
) (
  input  logic                          clk,
  input  logic                          start,
  input  logic                          step,
  input  logic [dpsu_pkg::SCALE_W-1:0]  dividend,
  input  logic [DVS_W-1:0]              divisor,
  output logic [dpsu_pkg::SCALE_W-1:0]  quotient
);
  import dpsu_pkg::*;

  logic [SCALE_W-1:0] q;
  logic [DVS_W-1:0]   r;
  logic [DVS_W-1:0]   d;
  logic [DVS_W:0]     sh;
  logic [DVS_W:0]     diff;
  logic               fits;

  assign sh       = {r, q[SCALE_W-1]};
  assign diff     = sh - {1'b0, d};
  assign fits     = sh >= {1'b0, d};
  assign quotient = q;

  // Load operands, then shift in one quotient bit per step
  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
      d <= divisor;
    end else if (step) begin
      q <= {q[SCALE_W-2:0], fits};
      r <= fits ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
    end
  end

endmodule

// ===== design/dpsu_dp.sv =====
// Datapath: channel state update, two period dividers and the result register.
module dpsu_dp #(
  parameter int CAPTURE_WIDTH        = dpsu_pkg::CAPTURE_WIDTH_DEF,
  parameter int OVERFLOW_COUNT_WIDTH = dpsu_pkg::OVERFLOW_COUNT_WIDTH_DEF,
  parameter int IN_W                 = 40,
  parameter int OUT_W                = 72
) (
  input  logic              clk,
  input  logic              rst,
  input  dpsu_pkg::cfg_t    cfg,
  input  dpsu_pkg::cmd_t    cmd,
  input  logic [IN_W-1:0]   s_tdata,
  output logic [OUT_W-1:0]  m_tdata
);
  import dpsu_pkg::*;

  localparam int CW     = CAPTURE_WIDTH;
  localparam int OW     = OVERFLOW_COUNT_WIDTH;
  localparam int BASE_W = (CW > MOD_W) ? CW : MOD_W;
  localparam int PW     = BASE_W + OW + 2;
  localparam int CMP_W  = (OW > MAXOVF_W) ? OW : MAXOVF_W;
  localparam int PROD_W = OW + MOD_W;

  logic                tick;
  logic [1:0]          cap;
  logic [CW-1:0]       cnt   [2];
  logic [CW-1:0]       last  [2];
  logic [OW-1:0]       ovf   [2];
  logic [PW-1:0]       period[2];
  logic                inv   [2];
  logic [SCALE_W-1:0]  quo   [2];
  logic [SPEED_W-1:0]  speed [2];

  // Unpack the input beat
  assign tick   = s_tdata[0];
  assign cap[0] = s_tdata[1];
  assign cnt[0] = s_tdata[2 +: CW];
  assign cap[1] = s_tdata[2 + CW];
  assign cnt[1] = s_tdata[3 + CW +: CW];

  for (genvar ch = 0; ch < 2; ch++) begin : g_lane
    logic [OW-1:0]     ovf_tick;
    logic [PW-1:0]     period_tick;
    logic [PROD_W-1:0] prod;
    logic [PW-1:0]     period_cap;
    logic              pos;

    // Overflow first, then capture
    always_comb begin
      ovf_tick    = (tick && (ovf[ch] != '1)) ? ovf[ch] + 1'b1 : ovf[ch];
      period_tick = (tick && (CMP_W'(ovf_tick) > CMP_W'(cfg.max_ovf))) ? '1 : period[ch];
      prod        = PROD_W'(ovf_tick) * PROD_W'(cfg.modulus);
      period_cap  = PW'(cnt[ch]) - PW'(last[ch]) + PW'(prod);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        last[ch]   <= '0;
        ovf[ch]    <= '0;
        period[ch] <= '0;
      end else if (cmd.update) begin
        if (cap[ch]) begin
          last[ch]   <= cnt[ch];
          ovf[ch]    <= '0;
          period[ch] <= period_cap;
        end else begin
          ovf[ch]    <= ovf_tick;
          period[ch] <= period_tick;
        end
      end
    end

    // Mark non-positive periods at divide start
    assign pos = !period[ch][PW-1] && (period[ch] != '0);

    always_ff @(posedge clk) begin
      if (cmd.div_start) begin
        inv[ch] <= !pos;
      end
    end

    dpsu_div #(
      .DVS_W (PW - 1)
    ) u_div (
      .clk      (clk),
      .start    (cmd.div_start),
      .step     (cmd.div_step),
      .dividend (cfg.scale),
      .divisor  (period[ch][PW-2:0]),
      .quotient (quo[ch])
    );

    assign speed[ch] = inv[ch] ? '1 : {1'b0, quo[ch]};
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= OUT_W'({speed[1], speed[0]});
    end
  end

endmodule

// ===== design/dpsu_ctrl.sv =====
// Controller: accepts a beat, sequences the divide and hands over the result.
module dpsu_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  output dpsu_pkg::cmd_t  cmd
);
  import dpsu_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t               state;
  logic [DIV_CNT_W-1:0] cnt;

  assign s_tready = (state == ST_IDLE);

  // Decode commands from the state
  always_comb begin
    cmd           = '0;
    cmd.update    = (state == ST_IDLE) && s_tvalid;
    cmd.div_start = (state == ST_START);
    cmd.div_step  = (state == ST_DIV);
    cmd.out_load  = (state == ST_DONE) && (!m_tvalid || m_tready);
  end

  // Advance state, count divide steps, track the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // Raise the result beat on the final load, drop it once taken
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_START;
          end
        end
        ST_START: begin
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == DIV_CNT_W'(SCALE_W - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== design/dual_encoder_period_speed_unit.sv =====
// Top level of the dual encoder period and speed unit.
//
//  channel | dir | contents
//  s_*     | in  | tdata: overflow_tick, left_capture, left_count, right_capture, right_count
//  m_*     | out | tdata: left_speed, right_speed
//  APB     | in  | counter_modulus @0x0, max_overflows @0x4, speed_scale @0x8
//
//  An item is handled in order: the channel state is updated on acceptance, the
//  dividers are loaded, the restoring dividers run (one quotient bit per cycle,
//  both channels in parallel) and the result register is loaded.
//  Reset clears the channel state and sets the registers to their defaults.
//  A waiting result does not block acceptance of the next beat; only the final
//  load waits while the result register is still full.
module dual_encoder_period_speed_unit #(
  parameter int CAPTURE_WIDTH        = dpsu_pkg::CAPTURE_WIDTH_DEF,
  parameter int OVERFLOW_COUNT_WIDTH = dpsu_pkg::OVERFLOW_COUNT_WIDTH_DEF,
  parameter int IN_W                 = ((3 + 2 * CAPTURE_WIDTH + 7) / 8) * 8,
  parameter int OUT_W                = ((2 * dpsu_pkg::SPEED_W + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // [0] overflow_tick, [1] left_capture, left_count, right_capture, right_count
  input  logic [IN_W-1:0]              s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // left_speed (33 bits), right_speed (33 bits)
  output logic [OUT_W-1:0]             m_tdata,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dpsu_pkg::ADDR_W-1:0]  paddr,
  input  logic [dpsu_pkg::DATA_W-1:0]  pwdata,
  output logic [dpsu_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import dpsu_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  dpsu_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dpsu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  dpsu_dp #(
    .CAPTURE_WIDTH        (CAPTURE_WIDTH),
    .OVERFLOW_COUNT_WIDTH (OVERFLOW_COUNT_WIDTH),
    .IN_W                 (IN_W),
    .OUT_W                (OUT_W)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cmd     (cmd),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata)
  );

endmodule

// ===== tb/dpsu_checker.sv =====
// Scoreboard of the dual encoder period and speed unit: tracks registers, predicts and compares speeds.
module dpsu_checker #(
  parameter int IN_W  = 40,
  parameter int OUT_W = 72
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [IN_W-1:0]             s_tdata,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [OUT_W-1:0]            m_tdata,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dpsu_pkg::ADDR_W-1:0] paddr,
  input  logic [dpsu_pkg::DATA_W-1:0] pwdata,
  input  logic                        pready,
  output int                          mismatches,
  output int                          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import dpsu_pkg::*;

  localparam int CAP_W    = CAPTURE_WIDTH_DEF;
  localparam int OVF_W    = OVERFLOW_COUNT_WIDTH_DEF;
  localparam int PERIOD_W = 26;
  localparam int LEFT     = 0;
  localparam int RIGHT    = 1;

  typedef struct packed {
    logic [SPEED_W-1:0] right;
    logic [SPEED_W-1:0] left;
  } speed_pair_t;

  // Own copy of the registers and of both channels
  logic [MOD_W-1:0]           modulus;
  logic [MAXOVF_W-1:0]        max_ovf;
  logic [SCALE_W-1:0]         scale;
  logic [CAP_W-1:0]           last_count [2];
  logic [OVF_W-1:0]           ovf_count [2];
  logic signed [PERIOD_W-1:0] period [2];

  speed_pair_t expected_speeds [$];
  int          fail_count = 0;

  // Truncating quotient, or all ones when the period is not positive
  function automatic logic [SPEED_W-1:0] speed_of_period(input logic signed [PERIOD_W-1:0] p);
    if (p > 0) return SPEED_W'(scale / SCALE_W'(p));
    return '1;
  endfunction

  // Overflow first, then left capture, then right capture; queue both speeds
  task automatic step_channels(input logic [IN_W-1:0] beat);
    logic             cap [2];
    logic [CAP_W-1:0] cnt [2];
    longint           p;
    int               ch;
    cap[LEFT]  = beat[1];
    cnt[LEFT]  = beat[2 +: CAP_W];
    cap[RIGHT] = beat[2 + CAP_W];
    cnt[RIGHT] = beat[3 + CAP_W +: CAP_W];
    if (beat[0]) begin
      for (ch = 0; ch < 2; ch++) begin
        if (ovf_count[ch] != '1) ovf_count[ch] = ovf_count[ch] + 1'b1;
        if (ovf_count[ch] > max_ovf) period[ch] = -1;
      end
    end
    for (ch = 0; ch < 2; ch++) begin
      if (cap[ch]) begin
        p = longint'(cnt[ch]) - longint'(last_count[ch])
            + longint'(ovf_count[ch]) * longint'(modulus);
        period[ch]     = PERIOD_W'(p);
        last_count[ch] = cnt[ch];
        ovf_count[ch]  = '0;
      end
    end
    expected_speeds.push_back('{right: speed_of_period(period[RIGHT]),
                                left:  speed_of_period(period[LEFT])});
  endtask

  always @(posedge clk) begin
    speed_pair_t want;
    if (rst) begin
      modulus = MODULUS_RST;
      max_ovf = MAX_OVF_RST;
      scale   = SCALE_RST;
      for (int ch = 0; ch < 2; ch++) begin
        last_count[ch] = '0;
        ovf_count[ch]  = '0;
        period[ch]     = '0;
      end
      expected_speeds.delete();
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_MODULUS: modulus = pwdata[MOD_W-1:0];
          REG_MAX_OVF: max_ovf = pwdata[MAXOVF_W-1:0];
          REG_SCALE:   scale   = pwdata[SCALE_W-1:0];
          default: ;
        endcase
      end
      // Compare an output beat with the oldest expectation
      if (m_tvalid && m_tready) begin
        if (expected_speeds.size() == 0) begin
          if (fail_count < 10)
            $display("%t: unexpected result left=%h right=%h", $realtime,
                     m_tdata[0 +: SPEED_W], m_tdata[SPEED_W +: SPEED_W]);
          fail_count++;
        end else begin
          want = expected_speeds.pop_front();
          if (m_tdata[0 +: SPEED_W] !== want.left ||
              m_tdata[SPEED_W +: SPEED_W] !== want.right) begin
            if (fail_count < 10)
              $display("%t: speed mismatch: expected left=%h right=%h, got left=%h right=%h",
                       $realtime, want.left, want.right,
                       m_tdata[0 +: SPEED_W], m_tdata[SPEED_W +: SPEED_W]);
            fail_count++;
          end
        end
      end
      // Predict for an input beat
      if (s_tvalid && s_tready) step_channels(s_tdata);
    end
    mismatches  <= fail_count;
    outstanding <= expected_speeds.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the testbench: clock, reset, stimulus, register set-up and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dpsu_pkg::*;

  localparam int CAP_W       = CAPTURE_WIDTH_DEF;
  localparam int IN_W        = ((3 + 2 * CAP_W + 7) / 8) * 8;
  localparam int OUT_W       = ((2 * SPEED_W + 7) / 8) * 8;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic [IN_W-1:0]   s_tdata  = '0;
  logic              m_tready = 1'b0;
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [ADDR_W-1:0] paddr    = '0;
  logic [DATA_W-1:0] pwdata   = '0;
  wire               s_tready;
  wire               m_tvalid;
  wire  [OUT_W-1:0]  m_tdata;
  wire  [DATA_W-1:0] prdata;
  wire               pready;

  int               mismatches;
  int               outstanding;
  int               quiet_cycles = 0;
  logic             calm         = 1'b0;
  bit               tx_clean     = 1'b0;
  logic [CAP_W-1:0] prev_left    = '0;
  logic [CAP_W-1:0] prev_right   = '0;

  dual_encoder_period_speed_unit u_top (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  dpsu_checker #(.IN_W(IN_W), .OUT_W(OUT_W)) u_checker (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatches, .outstanding
  );

  always #5 clk = ~clk;

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Drive m_tready: stall bursts, clean stretches and two long hold-offs
  initial begin : rx_side
    int idle_left;
    int beats_taken;
    bit clean;
    idle_left   = 0;
    beats_taken = 0;
    clean       = 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) beats_taken++;
      if (m_tvalid && m_tready && (beats_taken == 60 || beats_taken == 600)) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_left > 0) begin
        m_tready <= 1'b0;
        idle_left--;
      end else begin
        if ($urandom_range(0, 149) == 0) clean = !clean;
        if (!calm && !clean && $urandom_range(0, 3) == 0) begin
          m_tready  <= 1'b0;
          idle_left = $urandom_range(0, 7);
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  // Pack one event beat, first field in the lowest bits
  function automatic logic [IN_W-1:0] make_beat(input logic ovf, input logic lcap,
                                                input logic [CAP_W-1:0] lcnt,
                                                input logic rcap,
                                                input logic [CAP_W-1:0] rcnt);
    logic [IN_W-1:0] beat;
    beat                       = '0;
    beat[0]                    = ovf;
    beat[1]                    = lcap;
    beat[2 +: CAP_W]           = lcnt;
    beat[2 + CAP_W]            = rcap;
    beat[3 + CAP_W +: CAP_W]   = rcnt;
    return beat;
  endfunction

  // Next capture: half the time a plausible advance, otherwise random, backward or extreme
  function automatic logic [CAP_W-1:0] next_count(input logic [CAP_W-1:0] prev);
    case ($urandom_range(0, 7))
      0, 1:    return CAP_W'($urandom);
      2:       return prev - CAP_W'($urandom_range(0, 50));
      3:       return $urandom_range(0, 1) ? '1 : '0;
      default: return prev + CAP_W'($urandom_range(1, 3000));
    endcase
  endfunction

  // Offer one beat, with an occasional gap before it, and wait for acceptance
  task automatic push_event(input logic [IN_W-1:0] beat);
    if ($urandom_range(0, 149) == 0) tx_clean = !tx_clean;
    if (!calm && !tx_clean && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= beat;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop sending and wait until every expected result has come back
  task automatic settle_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // APB write: setup then access; psel is left high for back-to-back writes
  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  // Drain, then write all three registers
  task automatic configure(input logic [MOD_W-1:0] modulus, input logic [MAXOVF_W-1:0] max_ovf,
                           input logic [SCALE_W-1:0] scale);
    settle_results();
    write_reg(REG_MODULUS, DATA_W'(modulus));
    write_reg(REG_MAX_OVF, DATA_W'(max_ovf));
    write_reg(REG_SCALE, DATA_W'(scale));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random events; rates in per mille
  task automatic run_random(input int n, input int ovf_pm, input int cap_pm);
    logic             ovf;
    logic             lcap;
    logic             rcap;
    logic [CAP_W-1:0] lcnt;
    logic [CAP_W-1:0] rcnt;
    repeat (n) begin
      ovf  = $urandom_range(0, 999) < ovf_pm;
      lcap = $urandom_range(0, 999) < cap_pm;
      rcap = $urandom_range(0, 999) < cap_pm;
      lcnt = lcap ? next_count(prev_left) : CAP_W'($urandom);
      rcnt = rcap ? next_count(prev_right) : CAP_W'($urandom);
      if (lcap) prev_left = lcnt;
      if (rcap) prev_right = rcnt;
      push_event(make_beat(ovf, lcap, lcnt, rcap, rcnt));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: default registers
    push_event(make_beat(0, 0, 16'h0000, 0, 16'h0000));   // nothing captured yet
    push_event(make_beat(1, 0, 16'hFFFF, 0, 16'hFFFF));   // overflow alone
    push_event(make_beat(0, 1, 16'd100, 1, 16'hFFFF));
    push_event(make_beat(1, 1, 16'd200, 1, 16'h0000));    // overflow and capture together
    push_event(make_beat(0, 1, 16'd50, 1, 16'h0000));     // backward and equal captures
    push_event(make_beat(0, 1, 16'hFFFF, 1, 16'hFFFF));
    repeat (12) push_event(make_beat(1, 0, 16'h0000, 0, 16'h0000));  // past the limit
    push_event(make_beat(0, 1, 16'h0000, 1, 16'h0001));
    push_event(make_beat(0, 1, 16'h0001, 0, 16'h0000));   // period of one

    // Directed: zero modulus, no tolerated overflow, widest scale
    configure('0, '0, '1);
    push_event(make_beat(1, 0, 16'h0000, 0, 16'h0000));
    push_event(make_beat(1, 1, 16'd10, 1, 16'd20));
    push_event(make_beat(0, 1, 16'd5, 1, 16'd20));
    push_event(make_beat(0, 1, 16'hFFFF, 1, 16'hFFFF));

    // Directed: smallest modulus and scale, widest tolerance
    configure(16'd1, 8'd254, 32'd1);
    push_event(make_beat(1, 1, 16'h0000, 1, 16'h8000));
    push_event(make_beat(0, 1, 16'h0001, 1, 16'h8001));

    // Random: default registers, long receiver hold-off falls here
    configure(MODULUS_RST, MAX_OVF_RST, SCALE_RST);
    run_random(250, 250, 500);

    // Random registers, with a full drain in the middle
    configure(MOD_W'($urandom_range(1, 65535)), MAXOVF_W'($urandom_range(0, 254)),
              SCALE_W'($urandom_range(1, 32'hFFFF_FFFF)));
    run_random(120, 300, 400);
    settle_results();
    run_random(130, 100, 700);

    // Small extremes
    configure(16'd1, 8'd0, 32'd1);
    run_random(150, 400, 500);

    // Saturate the overflow counts, then capture for the longest periods
    configure('1, 8'd254, '1);
    run_random(280, 950, 0);
    run_random(40, 500, 300);

    // Last part with no idling on either side
    configure(MOD_W'($urandom_range(1, 65535)), MAXOVF_W'($urandom_range(0, 254)),
              SCALE_W'($urandom_range(1, 32'hFFFF_FFFF)));
    calm <= 1'b1;
    run_random(150, 250, 500);

    settle_results();
    repeat (80) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
